/* src/fhss_pkg.sv */
// Shared types and constants of the free hole size sorter.
package fhss_pkg;

  localparam int FIELD_W       = 31;
  localparam int MAX_HOLES_DEF = 32;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t hole_start;
    field_t hole_length;
    logic   last_hole;
  } hole_in_t;

  typedef struct packed {
    field_t sorted_start;
    field_t sorted_length;
    logic   last_sorted;
  } hole_out_t;

  // One stored hole as it sits in the list memory.
  typedef struct packed {
    field_t start;
    field_t length;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ0,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } state_t;

endpackage

/* src/fhss_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module fhss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fhss_ctrl.sv */
// Sequencer of the sorter: list loading, in-memory bubble passes and sorted read-out.
module fhss_ctrl
  import fhss_pkg::*;
#(
  parameter int MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hole_in_t                     in_data,
  input  logic                         sort_descending,
  output logic                         ram_we,
  output logic [$clog2(MAX_HOLES)-1:0] ram_waddr,
  output entry_t                       ram_wdata,
  output logic [$clog2(MAX_HOLES)-1:0] ram_raddr,
  input  entry_t                       ram_rdata,
  input  logic                         out_free,
  output logic                         out_load,
  output hole_out_t                    out_item
);

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HOLES);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pass_r, pass_nxt;
  entry_t        bubble_r, bubble_nxt;

  logic [CW-1:0] cnt_new;
  logic          swap;

  // Strict compare keeps equal lengths in arrival order.
  assign swap = sort_descending ? (bubble_r.length < ram_rdata.length)
                                : (bubble_r.length > ram_rdata.length);
  assign cnt_new = (cnt_r < MAX_CNT) ? CW'(cnt_r + ONE) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bubble_r <= bubble_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pass_nxt   = pass_r;
    bubble_nxt = bubble_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = bubble_r;
    ram_raddr  = '0;
    out_load   = 1'b0;
    out_item   = '{sorted_start:  ram_rdata.start,
                   sorted_length: ram_rdata.length,
                   last_sorted:   (CW'(idx_r + ONE) == cnt_r)};
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < MAX_CNT) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[AW-1:0];
            ram_wdata = '{start: in_data.hole_start, length: in_data.hole_length};
          end
          cnt_nxt = cnt_new;
          if (in_data.last_hole) begin
            pass_nxt  = '0;
            idx_nxt   = '0;
            state_nxt = (cnt_new > ONE) ? ST_READ0 : ST_EMIT_RD;
          end
        end
      end
      ST_READ0: begin
        ram_raddr = '0;
        idx_nxt   = ONE;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[AW-1:0];
        end
        if (idx_r == ONE) begin
          bubble_nxt = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(CW'(idx_r - TWO));
          if (swap) begin
            ram_wdata = ram_rdata;
          end else begin
            ram_wdata  = bubble_r;
            bubble_nxt = ram_rdata;
          end
        end
        idx_nxt = CW'(idx_r + ONE);
        if (idx_r == cnt_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(CW'(cnt_r - ONE));
        ram_wdata = bubble_r;
        pass_nxt  = CW'(pass_r + ONE);
        idx_nxt   = '0;
        state_nxt = (CW'(pass_r + TWO) == cnt_r) ? ST_EMIT_RD : ST_READ0;
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          ram_raddr = idx_r[AW-1:0];
          state_nxt = ST_EMIT_CAP;
        end
      end
      ST_EMIT_CAP: begin
        out_load = 1'b1;
        idx_nxt  = CW'(idx_r + ONE);
        if (CW'(idx_r + ONE) == cnt_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("entry count beyond capacity");

  a_sort_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_LOAD) |-> (CW'(ram_waddr) < cnt_r))
    else $error("sort write outside the stored list");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_item.last_sorted) |=> (cnt_r == '0 && state_r == ST_LOAD))
    else $error("list not emptied after final result");

endmodule

/* src/free_hole_size_sorter.sv */
// Top level of the free hole size sorter: list memory, sequencer, config and output register.
//
// Usage: holes arrive on the in_ channel (valid/ready), one transfer per hole,
// in_data carrying start offset, length and a last_hole marker. Holes are
// stored in arrival order in a MAX_HOLES deep memory at one transfer per cycle.
// Holes beyond MAX_HOLES are dropped; a dropped last hole still ends the list.
// On the last hole the block sorts the list in place with bubble passes and then
// sends every stored hole on the out_ channel, last_sorted marking the final transfer.
// The sort is stable, and cfg_data (written over the cfg_ channel while the block
// is idle) picks ascending (0) or descending (1) order by length.
// For a list of n holes the block loads the holes, then runs (n - 1) passes,
// each paced by the one read and one write port of the list memory, then reads
// out each result as a memory read followed by an output register load.
// in_ready is low from the last hole until the final result is loaded.
// A stalled receiver holds the output register; read-out waits until it frees.
// Reset (synchronous, active low) empties the list, clears the output valid flag
// and sets ascending order; memory contents are not cleared.
module free_hole_size_sorter
  import fhss_pkg::*;
#(
  parameter int MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hole_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hole_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int AW = $clog2(MAX_HOLES);

  logic             sort_desc_r;
  logic             out_valid_r;
  hole_out_t        out_data_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;

  logic             out_free;
  logic             out_load;
  hole_out_t        out_item;

  // The configuration register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_desc_r <= 1'b0;
    end else if (cfg_valid) begin
      sort_desc_r <= cfg_data;
    end
  end

  // Output register: it frees when empty or when its result transfers now.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  // The hole list: start offset and length side by side in one word.
  fhss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_HOLES)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fhss_ctrl #(
    .MAX_HOLES (MAX_HOLES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .sort_descending (sort_desc_r),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_free        (out_free),
    .out_load        (out_load),
    .out_item        (out_item)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the free hole size sorter: directed rows, then random hole lists.
`timescale 1ns / 100ps

module tb_top;
  import fhss_pkg::*;

  localparam int          CAPACITY      = MAX_HOLES_DEF;
  localparam int          RANDOM_HOLES  = 150;
  // Register writes wait this long once the list is drained, as extra margin
  // before the sort order changes.
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam field_t      FIELD_MAX     = {FIELD_W{1'b1}};

  localparam logic ORDER_ASCENDING  = 1'b0;
  localparam logic ORDER_DESCENDING = 1'b1;

  typedef enum { ROW_HOLE, ROW_ORDER } row_kind_t;

  // One row of the directed plan. A typed row carries its expected result,
  // which only happens for single-hole lists where the answer is the hole itself.
  typedef struct {
    row_kind_t kind;
    hole_in_t  item;
    logic      order;
    bit        typed;
    hole_out_t want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  hole_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hole_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // Predictor state: the holes stored so far in arrival order and the sort order.
  entry_t      held [CAPACITY];
  int          held_count;
  logic        order_model;
  hole_out_t   run_q[$];
  hole_out_t   pending_sorted[$];

  stim_row_t   plan[$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned holes_sent;
  int unsigned lists_sent;
  int unsigned overflow_lists;
  int unsigned results_checked = 0;
  int unsigned order_writes;

  // Receiver stall bookkeeping, only touched by the result checker below.
  int unsigned rx_hold;
  int unsigned rx_next;
  bit          rx_burst = 1'b0;

  free_hole_size_sorter #(
    .MAX_HOLES(CAPACITY)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_sorted.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stores one hole the way the sorter does and, when the hole closes the list,
  // leaves the sorted run in run_q. Insertion with a strict compare keeps holes
  // of equal length in arrival order, which is what a stable sort must give.
  function automatic void predict_sorter(input hole_in_t h);
    entry_t    moving;
    hole_out_t r;
    int        j;
    run_q.delete();
    // A full list drops the hole, even a closing one; the sort still runs.
    if (held_count < CAPACITY) begin
      held[held_count].start  = h.hole_start;
      held[held_count].length = h.hole_length;
      held_count++;
    end
    if (!h.last_hole) return;
    for (int i = 1; i < held_count; i++) begin
      moving = held[i];
      j = i;
      while (j > 0 && (order_model == ORDER_DESCENDING ?
                       moving.length > held[j-1].length :
                       moving.length < held[j-1].length)) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = moving;
    end
    for (int i = 0; i < held_count; i++) begin
      r.sorted_start  = held[i].start;
      r.sorted_length = held[i].length;
      r.last_sorted   = (i == held_count - 1);
      run_q.push_back(r);
    end
    held_count = 0;
  endfunction

  // Sends one hole after an optional idle gap and records what it should produce.
  // in_valid is only lowered when a gap follows, so back-to-back holes keep it
  // high without a second assignment in the same step.
  task automatic send_hole(input hole_in_t h, input int unsigned gap,
                           input bit typed, input hole_out_t want);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= h;
    do @(posedge clk); while (!in_ready);
    // The transfer happened at this edge.
    holes_sent++;
    if (h.last_hole) lists_sent++;
    predict_sorter(h);
    if (typed && h.last_hole) pending_sorted.push_back(want);
    else foreach (run_q[k]) pending_sorted.push_back(run_q[k]);
  endtask

  // Holds the sender off until every expected result has been checked, then
  // lets the sorter settle before anything else happens.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_sorted.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The order register is only written with the sorter idle and the list empty.
  task automatic write_order(input logic descending);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= descending;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    order_model  = descending;
    order_writes++;
  endtask

  task automatic add_hole(input field_t s, input field_t l, input logic last);
    stim_row_t row;
    row = '{kind: ROW_HOLE, item: '{s, l, last}, order: 1'b0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic add_typed(input field_t s, input field_t l,
                           input field_t want_s, input field_t want_l);
    stim_row_t row;
    row = '{kind: ROW_HOLE, item: '{s, l, 1'b1}, order: 1'b0, typed: 1'b1,
            want: '{want_s, want_l, 1'b1}};
    plan.push_back(row);
  endtask

  task automatic add_order(input logic descending);
    stim_row_t row;
    row = '{kind: ROW_ORDER, item: '0, order: descending, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  // Field values lean toward the extremes and, for lengths, toward a small
  // range so that equal lengths show up often and stability gets exercised.
  function automatic field_t draw_field(input bit is_length);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return field_t'(1);
        2:       return field_t'(FIELD_MAX - 1);
        default: return FIELD_MAX;
      endcase
    end
    if (pick < 5 && is_length) return field_t'($urandom_range(0, 7));
    return field_t'($urandom());
  endfunction

  // Result checker: every transfer on the out_ channel is compared with the
  // oldest expectation. After each transfer out_ready may stall at random,
  // with occasional bursts where the receiver never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else begin
      rx_next = (rx_hold != 0) ? rx_hold - 1 : 0;
      if (out_valid && out_ready) begin
        if (pending_sorted.size() == 0) begin
          flag_mismatch($sformatf("unexpected result start %h length %h last %b",
                                  out_data.sorted_start, out_data.sorted_length,
                                  out_data.last_sorted));
        end else begin
          if (out_data.sorted_start !== pending_sorted[0].sorted_start)
            flag_mismatch($sformatf("result %0d start got %h want %h", results_checked,
                                    out_data.sorted_start, pending_sorted[0].sorted_start));
          if (out_data.sorted_length !== pending_sorted[0].sorted_length)
            flag_mismatch($sformatf("result %0d length got %h want %h", results_checked,
                                    out_data.sorted_length, pending_sorted[0].sorted_length));
          if (out_data.last_sorted !== pending_sorted[0].last_sorted)
            flag_mismatch($sformatf("result %0d last got %b want %b", results_checked,
                                    out_data.last_sorted, pending_sorted[0].last_sorted));
          void'(pending_sorted.pop_front());
        end
        results_checked++;
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_next = rx_burst ? 0 : $urandom_range(0, 9);
      end
      rx_hold   <= rx_next;
      out_ready <= (rx_next == 0);
    end
  end

  initial begin
    hole_in_t    h;
    int unsigned list_no;
    int unsigned random_holes;
    int unsigned list_size;
    int unsigned pick;
    bit          burst;

    held_count      = 0;
    order_model     = ORDER_ASCENDING;
    holes_sent      = 0;
    lists_sent      = 0;
    overflow_lists  = 0;
    order_writes    = 0;

    // Directed plan. Single-hole lists come back unchanged with the last
    // marker set, so their results are written out here; longer lists go
    // through the predictor.
    add_order(ORDER_ASCENDING);
    add_typed('0, '0, '0, '0);
    add_typed(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    add_typed(31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555);
    add_typed(31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA);
    // Equal lengths must keep arrival order; the extreme lengths bracket them.
    add_hole(31'd100, 31'd5, 1'b0);
    add_hole(31'd200, 31'd3, 1'b0);
    add_hole(31'd300, 31'd5, 1'b0);
    add_hole(31'd400, 31'd3, 1'b0);
    add_hole(31'd500, FIELD_MAX, 1'b0);
    add_hole(31'd600, '0, 1'b1);
    // Already in ascending order, so nothing should move.
    add_hole(31'd1, 31'd1, 1'b0);
    add_hole(31'd2, 31'd2, 1'b0);
    add_hole(31'd3, 31'd3, 1'b1);
    add_order(ORDER_DESCENDING);
    add_typed(31'd123, 31'd456, 31'd123, 31'd456);
    add_hole(31'd100, 31'd5, 1'b0);
    add_hole(31'd200, 31'd3, 1'b0);
    add_hole(31'd300, 31'd5, 1'b0);
    add_hole(31'd400, 31'd3, 1'b0);
    add_hole(31'd500, FIELD_MAX, 1'b0);
    add_hole(31'd600, '0, 1'b1);
    add_hole(31'd7, 31'd9, 1'b0);
    add_hole(31'd8, 31'd9, 1'b1);
    add_order(ORDER_ASCENDING);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_ORDER)
        write_order(plan[i].order);
      else
        send_hole(plan[i].item, $urandom_range(0, 9), plan[i].typed, plan[i].want);
    end

    // Random lists. A few fixed slots hold a list that exactly fills the
    // store, one whose closing hole is dropped, and one that runs well past
    // capacity; the rest are mostly short so the run stays quick.
    list_no      = 0;
    random_holes = 0;
    while (random_holes < RANDOM_HOLES || list_no < 11) begin
      if (list_no == 1)
        wait_for_drain();
      else if ($urandom_range(0, 99) < 20)
        write_order(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 99) < 8)
        wait_for_drain();

      pick = $urandom_range(0, 99);
      case (list_no)
        2:       list_size = CAPACITY;
        6:       list_size = CAPACITY + 1;
        10:      list_size = CAPACITY + 4;
        default: list_size = (pick < 65) ? $urandom_range(1, 6) :
                             (pick < 90) ? $urandom_range(7, 16) :
                                           $urandom_range(17, CAPACITY - 1);
      endcase
      if (list_size > CAPACITY) overflow_lists++;

      burst = ($urandom_range(0, 99) < 30);
      for (int k = 0; k < list_size; k++) begin
        h.hole_start  = draw_field(1'b0);
        h.hole_length = draw_field(1'b1);
        h.last_hole   = (k == list_size - 1);
        send_hole(h, burst ? 0 : $urandom_range(0, 9), 1'b0, '0);
      end
      random_holes += list_size;
      list_no++;
    end

    // Drain the last results and give stray transfers a chance to show up.
    wait_for_drain();
    repeat (40) @(posedge clk);

    $display("covered %0d hole lists (%0d past capacity) with %0d holes in all",
             lists_sent, overflow_lists, holes_sent);
    $display("checked %0d sorted results over %0d order register writes",
             results_checked, order_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* free_hole_size_sorter.f */
src/fhss_pkg.sv
src/fhss_ram.sv
src/fhss_ctrl.sv
src/free_hole_size_sorter.sv
tb/tb_top.sv
